@@ rtl/core/generalized_fibonacci_raga_calc_unit_assert.svh @@
// Assertion macros for the generalized Fibonacci calculator.
// Each property is sampled on the rising clock edge and ignored while reset is low.
`ifndef GENERALIZED_FIBONACCI_RAGA_CALC_UNIT_ASSERT_SVH
`define GENERALIZED_FIBONACCI_RAGA_CALC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define GFRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define GFRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GFRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define GFRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/gfrc_pkg.sv @@
package gfrc_pkg;

  // Field widths
  localparam int ACTION_W = 3;
  localparam int VAL_W    = 16;
  localparam int IDX_W    = 7;
  localparam int RESULT_W = 48;
  localparam int K_W      = 6;
  localparam int GOAL_W   = 17;

  // Index search bound
  localparam logic [K_W-1:0] K_MAX = 6'd63;

  // Saturation value of every term
  localparam logic [RESULT_W-1:0] RESULT_MAX = 48'hFFFF_FFFF_FFFF;

  // pi/2 as a ratio: floor(b * pi/2) = floor(b * HALF_PI_NUM / HALF_PI_DEN)
  localparam int HALF_PI_W = 44;
  localparam logic [HALF_PI_W-1:0] HALF_PI_NUM = 44'd15707963267949;
  localparam logic [HALF_PI_W-1:0] HALF_PI_DEN = 44'd10000000000000;

  // Reciprocal form: ceil(HALF_PI_NUM * 2^60 / HALF_PI_DEN); the rounding error
  // times any 16-bit b stays below 1/HALF_PI_DEN, so the floor is exact
  localparam int RECIP_SHIFT = 60;
  localparam int RECIP_W     = 61;
  localparam logic [127:0] HALF_PI_RECIP_WIDE =
    ((128'(HALF_PI_NUM) << RECIP_SHIFT) + 128'(HALF_PI_DEN) - 128'd1) / 128'(HALF_PI_DEN);
  localparam logic [RECIP_W-1:0] HALF_PI_RECIP = HALF_PI_RECIP_WIDE[RECIP_W-1:0];

  // Shift-add multiply by the reciprocal
  localparam int MUL_STEPS = VAL_W;
  localparam int PROD_W    = RECIP_W + MUL_STEPS;
  localparam int CNT_W     = 5;
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);

  // Default upper bound of the seed recovery scan
  localparam int GFRC_SEED_SEARCH_LIMIT = 40;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TERM    = 3'd0,
    ACT_FIND    = 3'd1,
    ACT_INCR    = 3'd2,
    ACT_SPOKES  = 3'd3,
    ACT_RECOVER = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_TERM,
    S_FIND,
    S_MUL,
    S_DIV,
    S_BACK,
    S_STEP4,
    S_SCAN4,
    S_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic adv;
    logic back;
    logic mul;
    logic div;
    logic clr_cnt;
    logic acc_init;
    logic acc_step;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_t act;
    logic    idx_neg;
    logic    idx_hit;
    logic    k_bound;
    logic    k_zero;
    logic    goal_gt;
    logic    seed_gt;
    logic    b_odd;
    logic    mul_last;
    logic    acc_match;
    logic    n_limit;
  } status_t;

  // Add two terms, clamp at the saturation value
  function automatic logic [RESULT_W-1:0] sat_add(input logic [RESULT_W-1:0] x,
                                                  input logic [RESULT_W-1:0] y);
    logic [RESULT_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[RESULT_W] ? RESULT_MAX : s[RESULT_W-1:0];
  endfunction

endpackage

@@ rtl/core/gfrc_in_if.sv @@
interface gfrc_in_if;
  import gfrc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [VAL_W-1:0]           target;
  logic [VAL_W-1:0]           seed;
  logic signed [IDX_W-1:0]    term_index;

  modport source (output valid, output action, output target, output seed,
                  output term_index, input ready);
  modport sink   (input valid, input action, input target, input seed,
                  input term_index, output ready);
endinterface

@@ rtl/core/gfrc_out_if.sv @@
interface gfrc_out_if;
  import gfrc_pkg::*;

  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] result;
  logic                found;

  modport source (output valid, output result, output found, input ready);
  modport sink   (input valid, input result, input found, output ready);
endinterface

@@ rtl/core/gfrc_ctrl.sv @@
module gfrc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gfrc_pkg::status_t st,
  output gfrc_pkg::cmd_t    cmd
);
  import gfrc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Hold state and output flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequence one request through the datapath
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (st.act) inside
          ACT_TERM:            state_nxt = S_TERM;
          ACT_FIND, ACT_INCR:  state_nxt = S_FIND;
          ACT_SPOKES:          state_nxt = S_MUL;
          ACT_RECOVER:         state_nxt = S_STEP4;
          default:             state_nxt = S_FIN;
        endcase
      end
      S_TERM: begin
        if (st.idx_neg || st.idx_hit) begin
          state_nxt = S_FIN;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (st.mul_last) begin
          cmd.clr_cnt = 1'b1;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        // Take the scaled product as the goal
        cmd.div   = 1'b1;
        state_nxt = S_FIND;
      end
      S_FIND: begin
        if (st.goal_gt && !st.k_bound) begin
          cmd.adv = 1'b1;
        end else if (st.act == ACT_SPOKES) begin
          state_nxt = S_BACK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_BACK: begin
        // Step back to the nearest odd term
        if (!st.k_zero && !st.b_odd) begin
          cmd.back = 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_STEP4: begin
        if (st.seed_gt && !st.k_bound) begin
          cmd.adv = 1'b1;
        end else begin
          cmd.acc_init = 1'b1;
          state_nxt    = S_SCAN4;
        end
      end
      S_SCAN4: begin
        if (st.acc_match || st.n_limit) begin
          state_nxt = S_FIN;
        end else begin
          cmd.acc_step = 1'b1;
        end
      end
      S_FIN: begin
        // Load the output register once it is free
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.emit | (out_valid_r & ~out_ready);
  assign out_valid     = out_valid_r;

endmodule

@@ rtl/core/gfrc_dp.sv @@
module gfrc_dp #(
  parameter int SEED_SEARCH_LIMIT = gfrc_pkg::GFRC_SEED_SEARCH_LIMIT
) (
  input  logic                                clk,
  input  gfrc_pkg::cmd_t                      cmd,
  output gfrc_pkg::status_t                   st,
  input  logic [gfrc_pkg::ACTION_W-1:0]       in_action,
  input  logic [gfrc_pkg::VAL_W-1:0]          in_target,
  input  logic [gfrc_pkg::VAL_W-1:0]          in_seed,
  input  logic signed [gfrc_pkg::IDX_W-1:0]   in_term_index,
  output logic [gfrc_pkg::RESULT_W-1:0]       out_result,
  output logic                                out_found
);
  import gfrc_pkg::*;

  localparam int N_W = $clog2(SEED_SEARCH_LIMIT + 1);

  action_t                 act_r, act_nxt;
  logic [VAL_W-1:0]        tgt_r, tgt_nxt;
  logic [VAL_W-1:0]        sd_r, sd_nxt;
  logic signed [IDX_W-1:0] idx_r, idx_nxt;
  logic [GOAL_W-1:0]       goal_r, goal_nxt;
  logic [K_W-1:0]          k_r, k_nxt;
  // Term pair T(k-1), T(k)
  logic [RESULT_W-1:0]     a_r, a_nxt, b_r, b_nxt;
  // Coefficients: T(k) = A(k) + n * B(k), kept at k-1 and k
  logic [RESULT_W-1:0]     pa_r, pa_nxt, ca_r, ca_nxt;
  logic [RESULT_W-1:0]     pb_r, pb_nxt, cb_r, cb_nxt;
  logic [PROD_W-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [RESULT_W-1:0]     acc_r, acc_nxt;
  logic [N_W-1:0]          n_r, n_nxt;
  logic [RESULT_W-1:0]     result_r, result_nxt;
  logic                    found_r, found_nxt;

  logic [RESULT_W-1:0]     g_sum;
  logic [RESULT_W-1:0]     ab_sum;
  logic [RESULT_W-1:0]     res_sel;
  logic                    fnd_sel;

  // Seed-1 term at k-1 equals A(k-1) + B(k-1)
  assign g_sum  = pa_r + pb_r;
  assign ab_sum = sat_add(a_r, b_r);

  // Status toward the controller
  always_comb begin
    st.act       = act_r;
    st.idx_neg   = idx_r[IDX_W-1];
    st.idx_hit   = ({1'b0, k_r} == $unsigned(idx_r));
    st.k_bound   = (k_r == K_MAX);
    st.k_zero    = (k_r == '0);
    st.goal_gt   = (RESULT_W'(goal_r) > b_r);
    st.seed_gt   = (RESULT_W'(sd_r) > g_sum);
    st.b_odd     = b_r[0];
    st.mul_last  = (cnt_r == MUL_LAST);
    st.acc_match = (n_r != '0) && (acc_r == RESULT_W'(tgt_r));
    st.n_limit   = (n_r == N_W'(SEED_SEARCH_LIMIT));
  end

  // Pick the result of the current request
  always_comb begin
    res_sel = '0;
    fnd_sel = 1'b1;
    case (act_r)
      ACT_TERM:    res_sel = idx_r[IDX_W-1] ? RESULT_W'(sd_r) : b_r;
      ACT_FIND:    res_sel = RESULT_W'(k_r);
      ACT_INCR:    res_sel = g_sum;
      ACT_SPOKES:  res_sel = b_r;
      ACT_RECOVER: begin
        res_sel = st.acc_match ? RESULT_W'(n_r) : '0;
        fnd_sel = st.acc_match;
      end
      default: begin
        res_sel = '0;
        fnd_sel = 1'b0;
      end
    endcase
  end

  // Next values
  always_comb begin
    act_nxt    = act_r;
    tgt_nxt    = tgt_r;
    sd_nxt     = sd_r;
    idx_nxt    = idx_r;
    goal_nxt   = goal_r;
    k_nxt      = k_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    pa_nxt     = pa_r;
    ca_nxt     = ca_r;
    pb_nxt     = pb_r;
    cb_nxt     = cb_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    n_nxt      = n_r;
    result_nxt = result_r;
    found_nxt  = found_r;

    // Capture the request, start the sequence at index 0
    if (cmd.load) begin
      act_nxt  = action_t'(in_action);
      tgt_nxt  = in_target;
      sd_nxt   = in_seed;
      idx_nxt  = in_term_index;
      goal_nxt = GOAL_W'(in_target);
      k_nxt    = '0;
      a_nxt    = '0;
      b_nxt    = RESULT_W'(1);
      pa_nxt   = '0;
      ca_nxt   = RESULT_W'(1);
      pb_nxt   = RESULT_W'(1);
      cb_nxt   = '0;
      rem_nxt  = '0;
      cnt_nxt  = '0;
    end

    // Advance one index; index 1 is the seed itself
    if (cmd.adv) begin
      k_nxt  = k_r + K_W'(1);
      a_nxt  = b_r;
      pa_nxt = ca_r;
      pb_nxt = cb_r;
      if (k_r == '0) begin
        b_nxt  = RESULT_W'(sd_r);
        ca_nxt = '0;
        cb_nxt = RESULT_W'(1);
      end else begin
        b_nxt  = ab_sum;
        ca_nxt = ca_r + pa_r;
        cb_nxt = cb_r + pb_r;
      end
    end

    // Step back one index (terms are below saturation here)
    if (cmd.back) begin
      k_nxt = k_r - K_W'(1);
      b_nxt = a_r;
      a_nxt = b_r - a_r;
    end

    // One bit of target * HALF_PI_RECIP, MSB first
    if (cmd.mul) begin
      rem_nxt = {rem_r[PROD_W-2:0], 1'b0} +
                (tgt_r[VAL_W-1] ? PROD_W'(HALF_PI_RECIP) : '0);
      tgt_nxt = {tgt_r[VAL_W-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    // Drop the fraction bits of the product to get floor(target * pi/2)
    if (cmd.div) begin
      goal_nxt = rem_r[RECIP_SHIFT +: GOAL_W];
    end

    if (cmd.clr_cnt) begin
      cnt_nxt = '0;
    end

    // Seed scan: acc walks A + n * B
    if (cmd.acc_init) begin
      acc_nxt = ca_r;
      n_nxt   = '0;
    end
    if (cmd.acc_step) begin
      acc_nxt = sat_add(acc_r, cb_r);
      n_nxt   = n_r + N_W'(1);
    end

    if (cmd.emit) begin
      result_nxt = res_sel;
      found_nxt  = fnd_sel;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    tgt_r    <= tgt_nxt;
    sd_r     <= sd_nxt;
    idx_r    <= idx_nxt;
    goal_r   <= goal_nxt;
    k_r      <= k_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    pa_r     <= pa_nxt;
    ca_r     <= ca_nxt;
    pb_r     <= pb_nxt;
    cb_r     <= cb_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    n_r      <= n_nxt;
    result_r <= result_nxt;
    found_r  <= found_nxt;
  end

  assign out_result = result_r;
  assign out_found  = found_r;

endmodule

@@ rtl/core/generalized_fibonacci_raga_calc_unit.sv @@
// Channel   Dir  Payload                                   Handshake
// in_ch     in   action, target, seed, term_index          valid/ready
// out_ch    out  result, found                             valid/ready
//
// One request at a time; a term stepper advances one index per cycle.
// Term steps to the index; find/increment steps until the term reaches the goal;
// spoke count multiplies, then steps forward and back; seed recovery steps, then scans (<= limit).
// Synchronous active-low reset clears the controller and the output valid flag.
// A new request is taken while a finished result still waits in the output register.
module generalized_fibonacci_raga_calc_unit #(
  parameter int SEED_SEARCH_LIMIT = gfrc_pkg::GFRC_SEED_SEARCH_LIMIT
) (
  input  logic              clk,
  input  logic              rst_n,
  gfrc_in_if.sink           in_ch,
  gfrc_out_if.source        out_ch
);
  import gfrc_pkg::*;

  `include "generalized_fibonacci_raga_calc_unit_assert.svh"

  cmd_t    cmd;
  status_t st;

  gfrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  gfrc_dp #(
    .SEED_SEARCH_LIMIT (SEED_SEARCH_LIMIT)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .st            (st),
    .in_action     (in_ch.action),
    .in_target     (in_ch.target),
    .in_seed       (in_ch.seed),
    .in_term_index (in_ch.term_index),
    .out_result    (out_ch.result),
    .out_found     (out_ch.found)
  );

  // Busy after a request is taken
  `GFRC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "ready stayed high after accept")
  // Loading the output register raises valid
  `GFRC_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_ch.valid, "emit without valid")
  // A miss always carries a zero result
  `GFRC_ASSERT_NOW(a_miss_zero, clk, rst_n, out_ch.valid && !out_ch.found, out_ch.result == '0, "miss with nonzero result")
  // Never step past the index bound
  `GFRC_ASSERT_NOW(a_index_bound, clk, rst_n, cmd.adv, !st.k_bound, "index stepped past bound")

endmodule
